// ===== src/rcba_pkg.sv =====
// shared types and constants of the radiometer cell bin averager
package rcba_pkg;

    localparam int NFIELDS = 5;
    localparam int FLD_W   = 3;
    localparam int FIELD_W = 16;
    localparam int SUM_W   = 32;
    localparam int QCNT_W  = 5;

    localparam logic [FIELD_W-1:0] HOT_RESET = 16'd28500;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_HOT  = 2'd1;
    localparam logic [1:0] ST_POL  = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    localparam logic KIND_VERDICT = 1'b0;
    localparam logic KIND_READ    = 1'b1;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
    } t_div_req;

endpackage

// ===== src/rcba_ram.sv =====
// generic simple dual port ram with registered read
module rcba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/rcba_div.sv =====
// restoring divider, one quotient bit per cycle
module rcba_div #(
    parameter int DIV_W = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  rcba_pkg::t_div_req        i_req,
    input  logic [DIV_W-1:0]          i_divisor,
    output logic                      o_done,
    output logic [rcba_pkg::SUM_W-1:0] o_quot
);

    logic                        r_busy;
    logic                        r_done;
    logic [rcba_pkg::QCNT_W-1:0] r_step;
    logic [DIV_W:0]              r_rem;
    logic [rcba_pkg::SUM_W-1:0]  r_quot;
    logic [DIV_W:0]              w_trial;
    logic                        w_fits;

    assign w_trial = {r_rem[DIV_W-1:0], r_quot[rcba_pkg::SUM_W-1]};
    assign w_fits  = (w_trial >= {1'b0, i_divisor});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_rem  <= '0;
                r_quot <= i_req.dividend;
            end else if (r_busy) begin
                r_rem  <= w_fits ? (w_trial - {1'b0, i_divisor}) : w_trial;
                r_quot <= {r_quot[rcba_pkg::SUM_W-2:0], w_fits};
                r_step <= r_step + 1'b1;
                if (&r_step) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== src/radiometer_cell_bin_averager.sv =====
// top level: spot buffer, per-cell sums and counts, check and readout sequencer
// a non-final spot is taken while the block stays idle; a committed final spot gives its verdict
//   after a channel scan, then one read and one write per channel
// a refused verdict skips the memory writes; in a readout of a cell with data,
//   one shared 32-step divider serves all five fields
// one item is in work at a time, ready is low meanwhile
// reset (synchronous, active low) starts a clearing pass over every cell of the sums and
//   counts memories; no item is taken until it ends, config writes are taken
module radiometer_cell_bin_averager #(
    parameter int CELLS            = 4096,
    parameter int CHANNELS         = 19,
    parameter int CHECKED_CHANNELS = 16,
    parameter int COUNT_BITS       = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [11:0] i_cell_req,
    input  logic [4:0]  i_channel,
    input  logic [15:0] i_bright_temp,
    input  logic [15:0] i_land_fraction,
    input  logic [15:0] i_scan_field_a,
    input  logic [15:0] i_scan_field_b,
    input  logic [15:0] i_quality_field,
    input  logic        i_final_spot,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_kind,
    output logic [1:0]  o_status,
    output logic [15:0] o_cell_count,
    output logic [15:0] o_avg_temp,
    output logic [15:0] o_avg_land,
    output logic [15:0] o_avg_field_a,
    output logic [15:0] o_avg_field_b,
    output logic [15:0] o_avg_quality,
    output logic        o_no_data
);

    localparam int SLOTS  = CELLS * CHANNELS;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CH_W   = $clog2(CHANNELS);
    localparam int SPAN   = (CHECKED_CHANNELS < CHANNELS) ? CHECKED_CHANNELS : CHANNELS;
    localparam int ROW_W  = rcba_pkg::NFIELDS * rcba_pkg::SUM_W;
    localparam int BUF_W  = rcba_pkg::NFIELDS * rcba_pkg::FIELD_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_BASE  = 4'd1;
    localparam logic [3:0] S_CNT   = 4'd2;
    localparam logic [3:0] S_CHECK = 4'd3;
    localparam logic [3:0] S_DEC   = 4'd4;
    localparam logic [3:0] S_CRD   = 4'd5;
    localparam logic [3:0] S_CWR   = 4'd6;
    localparam logic [3:0] S_CNTWR = 4'd7;
    localparam logic [3:0] S_RDW   = 4'd8;
    localparam logic [3:0] S_RDV   = 4'd9;
    localparam logic [3:0] S_DIV   = 4'd10;
    localparam logic [3:0] S_EMIT  = 4'd11;
    localparam logic [3:0] S_WIPE  = 4'd12;

    logic [3:0]                        r_state;
    logic                              r_boot;
    logic [15:0]                       r_hot_limit;
    logic [1:0]                        r_cmd;
    logic [CELL_W-1:0]                 r_cell;
    logic                              r_cell_ok;
    logic [CH_W-1:0]                   r_ch;
    logic                              r_ch_ok;
    logic [SLOT_W-1:0]                 r_addr;
    logic [CH_W-1:0]                   r_idx;
    logic [COUNT_BITS-1:0]             r_cnt;
    logic                              r_hot_f;
    logic                              r_pol_f;
    logic [15:0]                       r_prev;
    logic [1:0]                        r_status;
    logic [ROW_W-1:0]                  r_row;
    logic [rcba_pkg::FLD_W-1:0]        r_fld;
    logic                              r_dstart;
    logic [15:0]                       r_avg [rcba_pkg::NFIELDS];
    logic [BUF_W-1:0]                  r_buf [CHANNELS];
    logic                              r_out_valid;
    logic                              r_kind;
    logic [1:0]                        r_o_status;
    logic [15:0]                       r_o_count;
    logic [15:0]                       r_o_avg [rcba_pkg::NFIELDS];
    logic                              r_o_nodata;

    logic                              w_accept;
    logic                              w_in_cell_ok;
    logic                              w_in_ch_ok;
    logic                              w_sum_we;
    logic [ROW_W-1:0]                  w_sum_wdata;
    logic [ROW_W-1:0]                  w_sum_rdata;
    logic                              w_cnt_we;
    logic [COUNT_BITS-1:0]             w_cnt_wdata;
    logic [COUNT_BITS-1:0]             w_cnt_rdata;
    logic [COUNT_BITS-1:0]             w_cnt_now;
    logic [15:0]                       w_temp;
    rcba_pkg::t_div_req                w_div_req;
    logic                              w_div_done;
    logic [rcba_pkg::SUM_W-1:0]        w_quot;
    logic                              w_emit;

    assign w_accept     = i_in_valid && o_in_ready;
    assign w_in_cell_ok = (32'(i_cell_req) < CELLS);
    assign w_in_ch_ok   = (32'(i_channel) < CHANNELS);
    assign w_cnt_now    = r_cell_ok ? w_cnt_rdata : '0;
    assign w_temp       = r_buf[r_idx][rcba_pkg::FIELD_W-1:0];
    assign w_emit       = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);

    // sums row update: one 32-bit add per field, all fields side by side
    always_comb begin
        w_sum_wdata = '0;
        if (r_state == S_CWR) begin
            for (int f = 0; f < rcba_pkg::NFIELDS; f++) begin
                w_sum_wdata[f*rcba_pkg::SUM_W +: rcba_pkg::SUM_W] =
                    w_sum_rdata[f*rcba_pkg::SUM_W +: rcba_pkg::SUM_W] +
                    32'(r_buf[r_idx][f*rcba_pkg::FIELD_W +: rcba_pkg::FIELD_W]);
            end
        end
    end

    assign w_sum_we    = (r_state == S_CWR) || (r_state == S_WIPE);
    assign w_cnt_we    = (r_state == S_CNTWR) || ((r_state == S_WIPE) && (r_idx == '0));
    assign w_cnt_wdata = (r_state == S_CNTWR) ? (r_cnt + 1'b1) : '0;

    assign w_div_req.start    = r_dstart;
    assign w_div_req.dividend = r_row[r_fld*rcba_pkg::SUM_W +: rcba_pkg::SUM_W];

    rcba_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SLOTS)
    ) u_sums (
        .i_clk   (i_clk),
        .i_we    (w_sum_we),
        .i_waddr (r_addr),
        .i_wdata (w_sum_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_sum_rdata)
    );

    rcba_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (CELLS)
    ) u_counts (
        .i_clk   (i_clk),
        .i_we    (w_cnt_we),
        .i_waddr (r_cell),
        .i_wdata (w_cnt_wdata),
        .i_raddr (r_cell),
        .o_rdata (w_cnt_rdata)
    );

    rcba_div #(
        .DIV_W (COUNT_BITS)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_div_req),
        .i_divisor (r_cnt),
        .o_done    (w_div_done),
        .o_quot    (w_quot)
    );

    // spot buffer, no reset
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_command == rcba_pkg::CMD_LOAD) && w_in_ch_ok) begin
            r_buf[i_channel[CH_W-1:0]] <= {i_quality_field, i_scan_field_b, i_scan_field_a,
                                           i_land_fraction, i_bright_temp};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_WIPE;
            r_boot      <= 1'b1;
            r_cell      <= '0;
            r_addr      <= '0;
            r_idx       <= '0;
            r_dstart    <= 1'b0;
            r_out_valid <= 1'b0;
            r_hot_limit <= rcba_pkg::HOT_RESET;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_hot_limit <= i_cfg_data;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd     <= i_command;
                        r_cell    <= CELL_W'(i_cell_req);
                        r_cell_ok <= w_in_cell_ok;
                        r_ch      <= i_channel[CH_W-1:0];
                        r_ch_ok   <= w_in_ch_ok;
                        if (((i_command == rcba_pkg::CMD_LOAD) && i_final_spot) ||
                            (i_command == rcba_pkg::CMD_READ) ||
                            ((i_command == rcba_pkg::CMD_CLEAR) && w_in_cell_ok)) begin
                            r_state <= S_BASE;
                        end
                    end
                end
                S_BASE: begin
                    r_addr  <= SLOT_W'(r_cell * SLOT_W'(CHANNELS));
                    r_state <= S_CNT;
                end
                S_CNT: begin
                    r_cnt   <= w_cnt_now;
                    r_idx   <= '0;
                    r_hot_f <= 1'b0;
                    r_pol_f <= 1'b0;
                    for (int f = 0; f < rcba_pkg::NFIELDS; f++) begin
                        r_avg[f] <= '0;
                    end
                    if (r_cmd == rcba_pkg::CMD_READ) begin
                        if ((w_cnt_now != '0) && r_ch_ok) begin
                            r_addr  <= r_addr + SLOT_W'(r_ch);
                            r_state <= S_RDW;
                        end else begin
                            r_state <= S_EMIT;
                        end
                    end else if (r_cmd == rcba_pkg::CMD_CLEAR) begin
                        r_state <= S_WIPE;
                    end else begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if ((32'(r_idx) < SPAN) && (w_temp > r_hot_limit)) begin
                        r_hot_f <= 1'b1;
                    end
                    // odd slot closes a pair whose even slot is inside the checked span
                    if (r_idx[0] && (32'(r_idx) - 1 < SPAN) && (r_prev > w_temp)) begin
                        r_pol_f <= 1'b1;
                    end
                    r_prev <= w_temp;
                    if (32'(r_idx) == CHANNELS - 1) begin
                        r_idx   <= '0;
                        r_state <= S_DEC;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_DEC: begin
                    priority if (r_hot_f) begin
                        r_status <= rcba_pkg::ST_HOT;
                        r_state  <= S_EMIT;
                    end else if (r_pol_f) begin
                        r_status <= rcba_pkg::ST_POL;
                        r_state  <= S_EMIT;
                    end else if (!r_cell_ok || (&r_cnt)) begin
                        r_status <= rcba_pkg::ST_FULL;
                        r_state  <= S_EMIT;
                    end else begin
                        r_status <= rcba_pkg::ST_OK;
                        r_state  <= S_CRD;
                    end
                end
                S_CRD: begin
                    r_state <= S_CWR;
                end
                S_CWR: begin
                    if (32'(r_idx) == CHANNELS - 1) begin
                        r_state <= S_CNTWR;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_addr  <= r_addr + 1'b1;
                        r_state <= S_CRD;
                    end
                end
                S_CNTWR: begin
                    r_cnt   <= r_cnt + 1'b1;
                    r_state <= S_EMIT;
                end
                S_RDW: begin
                    r_state <= S_RDV;
                end
                S_RDV: begin
                    r_row    <= w_sum_rdata;
                    r_fld    <= '0;
                    r_dstart <= 1'b1;
                    r_state  <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_avg[r_fld] <= w_quot[15:0];
                        if (32'(r_fld) == rcba_pkg::NFIELDS - 1) begin
                            r_dstart <= 1'b0;
                            r_state  <= S_EMIT;
                        end else begin
                            r_fld    <= r_fld + 1'b1;
                            r_dstart <= 1'b1;
                        end
                    end else begin
                        r_dstart <= 1'b0;
                    end
                end
                S_EMIT: begin
                    if (w_emit) begin
                        r_state <= S_IDLE;
                    end
                end
                S_WIPE: begin
                    if (32'(r_idx) == CHANNELS - 1) begin
                        r_idx <= '0;
                        if (r_boot && (32'(r_cell) != CELLS - 1)) begin
                            r_cell <= r_cell + 1'b1;
                            r_addr <= r_addr + 1'b1;
                        end else begin
                            r_boot  <= 1'b0;
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_idx  <= r_idx + 1'b1;
                        r_addr <= r_addr + 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result beat payload
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_kind     <= (r_cmd == rcba_pkg::CMD_READ) ? rcba_pkg::KIND_READ
                                                        : rcba_pkg::KIND_VERDICT;
            r_o_status <= (r_cmd == rcba_pkg::CMD_READ) ? rcba_pkg::ST_OK : r_status;
            r_o_count  <= 16'(r_cnt);
            r_o_nodata <= (r_cmd == rcba_pkg::CMD_READ) && (r_cnt == '0);
            for (int f = 0; f < rcba_pkg::NFIELDS; f++) begin
                r_o_avg[f] <= r_avg[f];
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_status      = r_o_status;
    assign o_cell_count  = r_o_count;
    assign o_avg_temp    = r_o_avg[0];
    assign o_avg_land    = r_o_avg[1];
    assign o_avg_field_a = r_o_avg[2];
    assign o_avg_field_b = r_o_avg[3];
    assign o_avg_quality = r_o_avg[4];
    assign o_no_data     = r_o_nodata;

`ifndef SYNTHESIS
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!w_sum_we && !w_cnt_we))
        else $error("memory write while idle");

    a_verdict_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind == rcba_pkg::KIND_VERDICT)) |->
        ((o_avg_temp == '0) && (o_avg_quality == '0) && !o_no_data))
        else $error("verdict beat carries readout fields");

    a_div_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside readout");

    a_commit_bumps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CNTWR) |=> ((r_state == S_EMIT) && (r_status == rcba_pkg::ST_OK)))
        else $error("count write not followed by accepted verdict");
`endif

endmodule

// ===== test/tb.sv =====
// testbench of the radiometer cell bin averager: directed and random spot streams
`timescale 1ns / 1ps

module tb;

    localparam int NCH     = 19;
    localparam int NCHK    = 16;
    localparam int NCELL   = 4096;
    localparam int CNT_MAX = 65535;

    typedef struct {
        logic [1:0]  cmd;
        logic [11:0] cell_id;
        logic [4:0]  ch;
        logic [15:0] fld [rcba_pkg::NFIELDS];
        logic        fin;
    } t_spot;

    typedef struct {
        logic        kind;
        logic [1:0]  status;
        logic [15:0] count;
        logic [15:0] avg [rcba_pkg::NFIELDS];
        logic        no_data;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_command;
    logic [11:0] i_cell_req;
    logic [4:0]  i_channel;
    logic [15:0] i_bright_temp;
    logic [15:0] i_land_fraction;
    logic [15:0] i_scan_field_a;
    logic [15:0] i_scan_field_b;
    logic [15:0] i_quality_field;
    logic        i_final_spot;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_kind;
    logic [1:0]  o_status;
    logic [15:0] o_cell_count;
    logic [15:0] o_avg_temp;
    logic [15:0] o_avg_land;
    logic [15:0] o_avg_field_a;
    logic [15:0] o_avg_field_b;
    logic [15:0] o_avg_quality;
    logic        o_no_data;

    radiometer_cell_bin_averager DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mirror of the block state
    logic [15:0] hot_lim;
    logic [15:0] spot_mem [rcba_pkg::NFIELDS][NCH];
    logic [31:0] cell_sums [rcba_pkg::NFIELDS][NCELL*NCH];
    logic [15:0] cell_cnt [NCELL];
    t_result     pending_results [$];

    int          errors = 0;
    int          burst_left = 0;
    bit          gaps_on = 1'b1;
    int          ready_pct = 100;
    int          spots_sent = 0;
    logic [11:0] cell_pool [8];

    task automatic predict_spot(input t_spot it);
        t_result r;
        logic [1:0] st;
        int base;
        r.kind = rcba_pkg::KIND_VERDICT;
        r.status = rcba_pkg::ST_OK;
        r.count = '0;
        r.no_data = 1'b0;
        for (int f = 0; f < rcba_pkg::NFIELDS; f++) r.avg[f] = '0;
        case (it.cmd)
            rcba_pkg::CMD_LOAD: begin
                if (it.ch < NCH)
                    for (int f = 0; f < rcba_pkg::NFIELDS; f++) spot_mem[f][it.ch] = it.fld[f];
                if (it.fin) begin
                    st = rcba_pkg::ST_OK;
                    for (int i = 0; i < NCHK; i++)
                        if (spot_mem[0][i] > hot_lim) st = rcba_pkg::ST_HOT;
                    if (st == rcba_pkg::ST_OK)
                        for (int i = 0; i + 1 < NCHK + 1 && i < NCHK && i + 1 < NCH; i += 2)
                            if (spot_mem[0][i] > spot_mem[0][i+1]) st = rcba_pkg::ST_POL;
                    if (st == rcba_pkg::ST_OK) begin
                        if (cell_cnt[it.cell_id] >= CNT_MAX) begin
                            st = rcba_pkg::ST_FULL;
                        end else begin
                            base = it.cell_id * NCH;
                            cell_cnt[it.cell_id]++;
                            for (int i = 0; i < NCH; i++)
                                for (int f = 0; f < rcba_pkg::NFIELDS; f++)
                                    cell_sums[f][base+i] += 32'(spot_mem[f][i]);
                        end
                    end
                    r.status = st;
                    r.count = cell_cnt[it.cell_id];
                    pending_results.push_back(r);
                end
            end
            rcba_pkg::CMD_READ: begin
                r.kind = rcba_pkg::KIND_READ;
                r.count = cell_cnt[it.cell_id];
                r.no_data = (cell_cnt[it.cell_id] == 0);
                if (cell_cnt[it.cell_id] != 0 && it.ch < NCH)
                    for (int f = 0; f < rcba_pkg::NFIELDS; f++)
                        r.avg[f] = 16'(cell_sums[f][it.cell_id*NCH+it.ch] /
                                       cell_cnt[it.cell_id]);
                pending_results.push_back(r);
            end
            rcba_pkg::CMD_CLEAR: begin
                cell_cnt[it.cell_id] = '0;
                for (int i = 0; i < NCH; i++)
                    for (int f = 0; f < rcba_pkg::NFIELDS; f++)
                        cell_sums[f][it.cell_id*NCH+i] = '0;
            end
            default: ;
        endcase
    endtask

    // leaves valid high after the beat so a following item goes out back to back
    task automatic send_spot(input t_spot it);
        if (gaps_on && burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0) burst_left--;
        i_in_valid      <= 1'b1;
        i_command       <= it.cmd;
        i_cell_req      <= it.cell_id;
        i_channel       <= it.ch;
        i_bright_temp   <= it.fld[0];
        i_land_fraction <= it.fld[1];
        i_scan_field_a  <= it.fld[2];
        i_scan_field_b  <= it.fld[3];
        i_quality_field <= it.fld[4];
        i_final_spot    <= it.fin;
        do @(posedge i_clk); while (!o_in_ready);
        predict_spot(it);
        spots_sent++;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        // a clear gives no result, so allow its cycles before going on
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_hot_limit(input logic [15:0] val);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        hot_lim = val;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_spot make_spot(input logic [1:0] cmd, input logic [11:0] cell_id,
                                        input logic [4:0] ch, input logic fin);
        t_spot s;
        s.cmd = cmd;
        s.cell_id = cell_id;
        s.ch = ch;
        s.fin = fin;
        for (int f = 0; f < rcba_pkg::NFIELDS; f++) s.fld[f] = 16'($urandom_range(0, 65535));
        return s;
    endfunction

    // mode: 0 clean, 1 one channel too hot, 2 one pair in wrong order
    task automatic send_observation(input logic [11:0] cell_id, input int mode);
        logic [15:0] tb_t [NCH];
        t_spot s;
        int k;
        for (int p = 0; p < NCHK; p += 2) begin
            tb_t[p]   = 16'($urandom_range(0, hot_lim));
            tb_t[p+1] = 16'($urandom_range(tb_t[p], hot_lim));
        end
        for (int i = NCHK; i < NCH; i++) tb_t[i] = 16'($urandom_range(0, 65535));
        if (mode == 1 && hot_lim != 16'hFFFF)
            tb_t[$urandom_range(0, NCHK-1)] = 16'($urandom_range(hot_lim + 1, 65535));
        else if (mode == 2 && hot_lim != 0) begin
            k = 2 * $urandom_range(0, NCHK/2 - 1);
            tb_t[k]   = 16'($urandom_range(1, hot_lim));
            tb_t[k+1] = 16'($urandom_range(0, tb_t[k] - 1));
        end
        for (int i = 0; i < NCH; i++) begin
            s = make_spot(rcba_pkg::CMD_LOAD, cell_id, 5'(i), i == NCH - 1);
            s.fld[0] = tb_t[i];
            send_spot(s);
        end
    endtask

    task automatic read_cell(input logic [11:0] cell_id, input logic [4:0] ch);
        send_spot(make_spot(rcba_pkg::CMD_READ, cell_id, ch, 1'($urandom_range(0, 1))));
    endtask

    always @(posedge i_clk) i_out_ready <= ($urandom_range(0, 99) < ready_pct);

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (o_kind !== e.kind) begin
                    $error("kind exp %0d got %0d", e.kind, o_kind); errors++;
                end
                if (o_status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_status); errors++;
                end
                if (o_cell_count !== e.count) begin
                    $error("cell_count exp %0d got %0d", e.count, o_cell_count); errors++;
                end
                if (o_avg_temp !== e.avg[0]) begin
                    $error("avg_temp exp %0d got %0d", e.avg[0], o_avg_temp); errors++;
                end
                if (o_avg_land !== e.avg[1]) begin
                    $error("avg_land exp %0d got %0d", e.avg[1], o_avg_land); errors++;
                end
                if (o_avg_field_a !== e.avg[2]) begin
                    $error("avg_field_a exp %0d got %0d", e.avg[2], o_avg_field_a); errors++;
                end
                if (o_avg_field_b !== e.avg[3]) begin
                    $error("avg_field_b exp %0d got %0d", e.avg[3], o_avg_field_b); errors++;
                end
                if (o_avg_quality !== e.avg[4]) begin
                    $error("avg_quality exp %0d got %0d", e.avg[4], o_avg_quality); errors++;
                end
                if (o_no_data !== e.no_data) begin
                    $error("no_data exp %0d got %0d", e.no_data, o_no_data); errors++;
                end
            end
        end
    end

    task automatic test_empty_store();
        read_cell(12'd0, 5'd0);
        read_cell(12'd4095, 5'd31);
        settle();
    endtask

    task automatic test_first_commit();
        t_spot s;
        // fill the whole buffer first, extreme field values included
        for (int i = 0; i < NCH; i++) begin
            s = make_spot(rcba_pkg::CMD_LOAD, 12'd4095, 5'(i), i == NCH - 1);
            s.fld[0] = (i >= NCHK) ? 16'hFFFF : 16'd0;
            s.fld[1] = 16'hFFFF;
            s.fld[2] = 16'h0000;
            send_spot(s);
        end
        send_observation(12'd4095, 0);
        read_cell(12'd4095, 5'd18);
        read_cell(12'd4095, 5'd0);
        read_cell(12'd4095, 5'd31);
        settle();
    endtask

    task automatic test_quality_check();
        t_spot s;
        send_observation(12'd0, 1);
        send_observation(12'd0, 2);
        // final flag on a slot outside the buffer, stale contents decide
        s = make_spot(rcba_pkg::CMD_LOAD, 12'd0, 5'd25, 1'b1);
        send_spot(s);
        // reload one channel only and commit again
        s = make_spot(rcba_pkg::CMD_LOAD, 12'd0, 5'd17, 1'b1);
        send_spot(s);
        read_cell(12'd0, 5'd17);
        settle();
    endtask

    task automatic test_clear_and_unused();
        send_spot(make_spot(rcba_pkg::CMD_CLEAR, 12'd4095, 5'd0, 1'b0));
        send_spot(make_spot(rcba_pkg::CMD_UNUSED, 12'd0, 5'd3, 1'b1));
        read_cell(12'd4095, 5'd5);
        read_cell(12'd0, 5'd3);
        settle();
    endtask

    task automatic test_limit_extremes();
        write_hot_limit(16'd0);
        send_observation(12'd7, 0);
        send_observation(12'd7, 1);
        write_hot_limit(16'hFFFF);
        send_observation(12'd7, 0);
        send_observation(12'd7, 2);
        read_cell(12'd7, 5'd2);
        settle();
    endtask

    task automatic test_random_traffic(input int n_items, input int pct, input bit gaps);
        int stop_at;
        int pick;
        ready_pct = pct;
        gaps_on = gaps;
        stop_at = spots_sent + n_items;
        while (spots_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                send_observation(cell_pool[$urandom_range(0, 7)],
                                 ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 2));
            else if (pick < 65) begin
                // partial reload over a stale buffer
                repeat ($urandom_range(0, 3))
                    send_spot(make_spot(rcba_pkg::CMD_LOAD, cell_pool[0],
                                        5'($urandom_range(0, 31)), 1'b0));
                send_spot(make_spot(rcba_pkg::CMD_LOAD, cell_pool[$urandom_range(0, 7)],
                                    5'($urandom_range(0, 31)), 1'b1));
            end else if (pick < 85)
                read_cell(($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095))
                                                      : cell_pool[$urandom_range(0, 7)],
                          5'($urandom_range(0, 31)));
            else if (pick < 90)
                send_spot(make_spot(rcba_pkg::CMD_CLEAR, ($urandom_range(0, 1) == 0)
                                    ? 12'($urandom_range(0, 4095))
                                    : cell_pool[$urandom_range(0, 7)],
                                    5'($urandom_range(0, 31)), 1'($urandom_range(0, 1))));
            else if (pick < 95)
                send_spot(make_spot(rcba_pkg::CMD_LOAD, 12'($urandom_range(0, 4095)),
                                    5'($urandom_range(NCH, 31)), 1'b0));
            else
                send_spot(make_spot(rcba_pkg::CMD_UNUSED, 12'($urandom_range(0, 4095)),
                                    5'($urandom_range(0, 31)), 1'($urandom_range(0, 1))));
        end
        settle();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_command = rcba_pkg::CMD_LOAD;
        i_cell_req = '0;
        i_channel = '0;
        i_bright_temp = '0;
        i_land_fraction = '0;
        i_scan_field_a = '0;
        i_scan_field_b = '0;
        i_quality_field = '0;
        i_final_spot = 1'b0;
        hot_lim = rcba_pkg::HOT_RESET;
        for (int c = 0; c < NCELL; c++) cell_cnt[c] = '0;
        for (int f = 0; f < rcba_pkg::NFIELDS; f++)
            for (int j = 0; j < NCELL*NCH; j++) cell_sums[f][j] = '0;
        for (int i = 0; i < 8; i++) cell_pool[i] = 12'($urandom_range(0, 4095));
        cell_pool[0] = 12'd0;
        cell_pool[1] = 12'd4095;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_store();
        test_first_commit();
        test_quality_check();
        test_clear_and_unused();
        ready_pct = 40;
        test_limit_extremes();
        write_hot_limit(rcba_pkg::HOT_RESET);
        test_random_traffic(120, 100, 1'b0);
        write_hot_limit(16'($urandom_range(1000, 65534)));
        test_random_traffic(110, 35, 1'b1);
        write_hot_limit(16'($urandom_range(0, 65535)));
        test_random_traffic(100, 75, 1'b1);

        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb failed");
        $finish;
    end

endmodule
